FILE: rtl/eci_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eci_pkg
// Shared constants and types for the easing curve interpolator.
// ----------------------------------------------------------------------------
package eci_pkg;

    localparam int TIME_BITS = 32;
    localparam int PH_FRAC   = 16;
    localparam int PH_W      = PH_FRAC + 1;
    localparam int VAL_W     = 32;
    localparam int KIND_W    = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [PH_W-1:0] PH_ONE  = PH_W'(1) << PH_FRAC;
    localparam logic [PH_W-1:0] PH_HALF = PH_ONE >> 1;

    typedef enum logic [KIND_W-1:0] {
        K_LIN     = 4'd0,
        K_PULSE   = 4'd1,
        K_QIN     = 4'd2,
        K_QOUT    = 4'd3,
        K_QINOUT  = 4'd4,
        K_QOUTIN  = 4'd5,
        K_CIN     = 4'd6,
        K_COUT    = 4'd7,
        K_CINOUT  = 4'd8,
        K_COUTIN  = 4'd9
    } t_kind;

    typedef enum logic [2:0] {
        M_LIN,
        M_PULSE,
        M_IN,
        M_OUT,
        M_INOUT,
        M_OUTIN
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KIND  = 2'd0,
        CFG_START = 2'd1,
        CFG_DIFF  = 2'd2,
        CFG_END   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic clamped;
        logic zero;
    } t_side;

endpackage

FILE: rtl/easing_curve_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// easing_curve_interpolator
// Eased value = start + diff * f(min(t, end) / end), Q16.16, saturated.
// The path runs through the one-bit-per-stage phase divider, then the curve
// multipliers and the final add.
// Throughput: one word per cycle; the whole pipe holds only while the output
// word waits under stall. Synchronous active-low reset clears valids and
// returns registers to linear, start 0, diff 0, end_time 1.
// ----------------------------------------------------------------------------
module easing_curve_interpolator import eci_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [VAL_W-1:0]            i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [TIME_BITS-1:0]        i_elapsed_time,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [VAL_W-1:0]     o_eased_value,
    output logic                        o_time_clamped,
    output logic                        o_value_saturated
);

    localparam int PRW = VAL_W + PH_W + 1;
    localparam int SW  = PRW - PH_FRAC + 1;
    localparam logic signed [SW-1:0] VMAX = SW'({1'b0, {(VAL_W-1){1'b1}}});
    localparam logic signed [SW-1:0] VMIN = -VMAX - SW'(1);

    logic [KIND_W-1:0]       r_kind;
    logic signed [VAL_W-1:0] r_start;
    logic signed [VAL_W-1:0] r_diff;
    logic [TIME_BITS-1:0]    r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= K_LIN;
            r_start <= '0;
            r_diff  <= '0;
            r_end   <= TIME_BITS'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_KIND:  r_kind  <= i_cfg_data[KIND_W-1:0];
                CFG_START: r_start <= i_cfg_data;
                CFG_DIFF:  r_diff  <= i_cfg_data;
                CFG_END:   r_end   <= i_cfg_data[TIME_BITS-1:0];
                default:   ;
            endcase
        end
    end

    logic ce;
    logic r_o_vld;
    assign ce      = !(r_o_vld && i_stall);
    assign o_stall = !ce;

    // input clamp
    logic [TIME_BITS-1:0] n_t;
    t_side                n_side;
    always_comb begin
        n_side.clamped = i_elapsed_time > r_end;
        n_side.zero    = r_end == '0;
        n_t            = n_side.clamped ? r_end : i_elapsed_time;
    end

    logic            d_vld;
    logic [PH_W-1:0] d_phase;
    t_side           d_side;

    eci_phase_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (i_valid),
        .i_time  (n_t),
        .i_div   (r_end),
        .i_side  (n_side),
        .o_valid (d_vld),
        .o_phase (d_phase),
        .o_side  (d_side)
    );

    // stage A: curve decode and operand
    logic [PH_W-1:0] n_a_p, n_a_x, n_a_p2;
    logic            n_a_lo, n_a_cub;
    t_mode           n_a_mode;
    always_comb begin
        n_a_p   = d_side.zero ? PH_ONE : d_phase;
        n_a_lo  = n_a_p < PH_HALF;
        n_a_p2  = {n_a_p[PH_W-2:0], 1'b0};
        n_a_cub = 1'b0;
        case (t_kind'(r_kind))
            K_PULSE:  n_a_mode = M_PULSE;
            K_QIN:    n_a_mode = M_IN;
            K_QOUT:   n_a_mode = M_OUT;
            K_QINOUT: n_a_mode = M_INOUT;
            K_QOUTIN: n_a_mode = M_OUTIN;
            K_CIN:    begin n_a_mode = M_IN;    n_a_cub = 1'b1; end
            K_COUT:   begin n_a_mode = M_OUT;   n_a_cub = 1'b1; end
            K_CINOUT: begin n_a_mode = M_INOUT; n_a_cub = 1'b1; end
            K_COUTIN: begin n_a_mode = M_OUTIN; n_a_cub = 1'b1; end
            default:  n_a_mode = M_LIN;
        endcase
        case (n_a_mode)
            M_OUT:   n_a_x = PH_ONE - n_a_p;
            M_INOUT: n_a_x = n_a_lo ? n_a_p2 : PH_W'({PH_ONE - n_a_p, 1'b0});
            M_OUTIN: n_a_x = n_a_lo ? PH_ONE - n_a_p2 : n_a_p2 - PH_ONE;
            default: n_a_x = n_a_p;
        endcase
    end

    logic            r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld;
    logic [PH_W-1:0] r_a_x, r_a_p, r_b_x, r_b_sq, r_b_p, r_c_iv, r_c_p, r_d_f;
    logic            r_a_lo, r_a_cub, r_b_lo, r_b_cub, r_c_lo;
    t_mode           r_a_mode, r_b_mode, r_c_mode;
    t_side           r_a_side, r_b_side, r_c_side, r_d_side, r_e_side;
    logic signed [PRW-1:0] r_e_prod;

    // stage B: square
    logic [2*PH_W-1:0] n_b_sq;
    assign n_b_sq = r_a_x * r_a_x;

    // stage C: cube
    logic [2*PH_W-1:0] n_c_cu;
    assign n_c_cu = r_b_sq * r_b_x;

    // stage D: curve shaping
    logic [PH_W-1:0] n_d_f;
    always_comb begin
        case (r_c_mode)
            M_PULSE: n_d_f = r_c_lo ? '0 : PH_ONE;
            M_IN:    n_d_f = r_c_iv;
            M_OUT:   n_d_f = PH_ONE - r_c_iv;
            M_INOUT: n_d_f = r_c_lo ? r_c_iv >> 1 : PH_ONE - (r_c_iv >> 1);
            M_OUTIN: n_d_f = r_c_lo ? (PH_ONE - r_c_iv) >> 1 : PH_HALF + (r_c_iv >> 1);
            default: n_d_f = r_c_p;
        endcase
    end

    // stages E and O: scale, offset, saturate
    logic signed [SW-1:0] n_o_sum;
    assign n_o_sum = SW'(r_e_prod >>> PH_FRAC) + SW'(r_start);

    logic signed [VAL_W-1:0] r_o_val;
    logic                    r_o_clamp, r_o_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (ce) begin
            r_a_vld <= d_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
            r_o_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_a_x    <= n_a_x;
            r_a_p    <= n_a_p;
            r_a_lo   <= n_a_lo;
            r_a_cub  <= n_a_cub;
            r_a_mode <= n_a_mode;
            r_a_side <= d_side;

            r_b_sq   <= PH_W'(n_b_sq >> PH_FRAC);
            r_b_x    <= r_a_x;
            r_b_p    <= r_a_p;
            r_b_lo   <= r_a_lo;
            r_b_cub  <= r_a_cub;
            r_b_mode <= r_a_mode;
            r_b_side <= r_a_side;

            r_c_iv   <= r_b_cub ? PH_W'(n_c_cu >> PH_FRAC) : r_b_sq;
            r_c_p    <= r_b_p;
            r_c_lo   <= r_b_lo;
            r_c_mode <= r_b_mode;
            r_c_side <= r_b_side;

            r_d_f    <= n_d_f;
            r_d_side <= r_c_side;

            r_e_prod <= PRW'(r_diff) * $signed(PRW'({1'b0, r_d_f}));
            r_e_side <= r_d_side;

            r_o_clamp <= r_e_side.clamped;
            if (n_o_sum > VMAX) begin
                r_o_val <= VMAX[VAL_W-1:0];
                r_o_sat <= 1'b1;
            end else if (n_o_sum < VMIN) begin
                r_o_val <= VMIN[VAL_W-1:0];
                r_o_sat <= 1'b1;
            end else begin
                r_o_val <= n_o_sum[VAL_W-1:0];
                r_o_sat <= 1'b0;
            end
        end
    end

    assign o_valid           = r_o_vld;
    assign o_eased_value     = r_o_val;
    assign o_time_clamped    = r_o_clamp;
    assign o_value_saturated = r_o_sat;

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_value_saturated) |->
            (o_eased_value == VMAX[VAL_W-1:0] || o_eased_value == VMIN[VAL_W-1:0]))
        else $error("saturated word not at a bound");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall not tied to output backpressure");

    a_zero_diff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_diff == '0) |-> (o_eased_value == r_start && !o_value_saturated))
        else $error("zero change did not return start value");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

FILE: rtl/eci_phase_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eci_phase_div
// Pipelined restoring divider: phase = floor(t * 2^PH_FRAC / d), t <= d.
// One quotient bit per stage, PH_FRAC + 1 stages.
// ----------------------------------------------------------------------------
module eci_phase_div import eci_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_ce,
    input  logic                 i_valid,
    input  logic [TIME_BITS-1:0] i_time,
    input  logic [TIME_BITS-1:0] i_div,
    input  t_side                i_side,
    output logic                 o_valid,
    output logic [PH_W-1:0]      o_phase,
    output t_side                o_side
);

    logic [TIME_BITS-1:0] r_rem  [0:PH_FRAC];
    logic [PH_W-1:0]      r_quo  [0:PH_FRAC];
    logic                 r_vld  [0:PH_FRAC];
    t_side                r_side [0:PH_FRAC];

    logic n_ge0;
    assign n_ge0 = i_time >= i_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_ce) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem[0]  <= n_ge0 ? i_time - i_div : i_time;
            r_quo[0]  <= PH_W'(n_ge0);
            r_side[0] <= i_side;
        end
    end

    for (genvar g = 1; g <= PH_FRAC; g++) begin : g_step
        logic [TIME_BITS:0] n_shift;
        logic               n_ge;
        assign n_shift = {r_rem[g-1], 1'b0};
        assign n_ge    = n_shift >= {1'b0, i_div};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_ce) begin
                r_vld[g] <= r_vld[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[g]  <= n_ge ? TIME_BITS'(n_shift - {1'b0, i_div})
                                  : n_shift[TIME_BITS-1:0];
                r_quo[g]  <= {r_quo[g-1][PH_W-2:0], n_ge};
                r_side[g] <= r_side[g-1];
            end
        end
    end

    assign o_valid = r_vld[PH_FRAC];
    assign o_phase = r_quo[PH_FRAC];
    assign o_side  = r_side[PH_FRAC];

endmodule
